>>> hdl/sm4_pkg.sv
// ----------------------------------------------------------------------------
// sm4_pkg
// shared types, constants and round functions of the sm4 cipher unit
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RkIdxW    = $clog2(NumRounds);

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        opcode;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  // words x0..x3 from msb down, decrypt flag rides along
  typedef struct packed {
    logic [127:0] x;
    logic         dec;
  } stage_t;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } opcode_e;

  typedef enum logic {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } reg_idx_e;

  localparam logic [127:0] FamKey = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;

  localparam logic [7:0] Sbox [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] a);
    return {Sbox[a[31:24]], Sbox[a[23:16]], Sbox[a[15:8]], Sbox[a[7:0]]};
  endfunction

  function automatic logic [31:0] lin_data(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  function automatic logic [31:0] lin_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // byte j of ck(i), msb first, is (4i + j) * 7 mod 256
  function automatic logic [31:0] const_key(input logic [RkIdxW-1:0] i);
    logic [31:0] w;
    logic [7:0]  n;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      n = {1'b0, i, 2'b00} + 8'(j);
      w = {w[23:0], 8'(n * 8'd7)};
    end
    return w;
  endfunction

  // one round: shift words left, append x0 ^ T(x1 ^ x2 ^ x3 ^ rk)
  function automatic logic [127:0] round_fn(input logic [127:0] x,
                                            input logic [31:0]  rk);
    logic [31:0] t;
    t = x[95:64] ^ x[63:32] ^ x[31:0] ^ rk;
    return {x[95:0], x[127:96] ^ lin_data(tau(t))};
  endfunction

endpackage

>>> hdl/sm4_key_sched.sv
// ----------------------------------------------------------------------------
// sm4_key_sched
// iterative key expansion, one round key per cycle, into 32 key registers
// ----------------------------------------------------------------------------
module sm4_key_sched (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  logic [127:0]                                key_i,
  output logic                                        busy_o,
  output logic [sm4_pkg::NumRounds-1:0][31:0]         rk_o
);
  import sm4_pkg::*;

  logic [127:0]                 k_q, k_d;
  logic [RkIdxW-1:0]            cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic [31:0]                  new_rk;
  logic [NumRounds-1:0][31:0]   rk_q;

  always_comb begin
    new_rk = k_q[127:96]
           ^ lin_key(tau(k_q[95:64] ^ k_q[63:32] ^ k_q[31:0] ^ const_key(cnt_q)));
    k_d    = k_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (load_i) begin
      k_d    = key_i ^ FamKey;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      k_d    = {k_q[95:0], new_rk};
      cnt_d  = cnt_q + 1'b1;
      busy_d = (cnt_q != RkIdxW'(NumRounds - 1));
    end
  end

  // reset key is all zero, so the schedule restarts from the family key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= FamKey;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      k_q    <= k_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !load_i) begin
      rk_q[cnt_q] <= new_rk;
    end
  end

  assign busy_o = busy_q;
  assign rk_o   = rk_q;

endmodule

>>> hdl/sm4_round.sv
// ----------------------------------------------------------------------------
// sm4_round
// one cipher round followed by its pipeline register
// ----------------------------------------------------------------------------
module sm4_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  sm4_pkg::stage_t  data_i,
  input  logic [31:0]      rk_enc_i,
  input  logic [31:0]      rk_dec_i,
  output logic             valid_o,
  output sm4_pkg::stage_t  data_o
);
  import sm4_pkg::*;

  logic   valid_q;
  stage_t data_q, data_d;

  always_comb begin
    data_d.dec = data_i.dec;
    data_d.x   = round_fn(data_i.x, (data_i.dec == OpDecrypt) ? rk_dec_i : rk_enc_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hdl/sm4_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// sm4_block_cipher_unit
// sm4 block cipher, 128-bit key, fully unrolled 32-round pipeline
// ----------------------------------------------------------------------------
// usage:
//   the key is written over the apb port as two 64-bit registers, key_high
//   at address 0 and key_low at address 8; every write restarts the key
//   schedule, which produces one round key per cycle.
//   while the schedule runs, in_stall_o is held high.
//   after reset the schedule runs once for the all-zero key, so the input
//   channel opens only once that run is done.
//   each input transfer carries one 128-bit block and an opcode (encrypt or
//   decrypt). the block passes through 32 round stages, one per cycle
//   while the pipeline moves. a new block is taken every cycle unless
//   in_stall_o is high, so sustained throughput is one block per cycle, set
//   by the one-round stage register depth.
//   when the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o rises; empty slots still move while the output is free.
// ----------------------------------------------------------------------------
module sm4_block_cipher_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sm4_pkg::in_item_t  in_data_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sm4_pkg::out_item_t out_data_o
);
  import sm4_pkg::*;

  logic [63:0]                 key_high_q, key_high_d;
  logic [63:0]                 key_low_q, key_low_d;
  logic                        cfg_wr;
  reg_idx_e                    cfg_idx;
  logic                        ks_busy;
  logic [NumRounds-1:0][31:0]  rk;
  logic                        pipe_en;
  logic                        in_xfer;
  logic [NumRounds:0]          stg_valid;
  stage_t                      stg_data [NumRounds+1];

  // register file: bit 3 of the address picks the register
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    key_high_d = key_high_q;
    key_low_d  = key_low_q;
    if (cfg_wr) begin
      case (cfg_idx)
        RegKeyHigh: key_high_d = pwdata;
        RegKeyLow:  key_low_d  = pwdata;
        default:    key_high_d = key_high_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegKeyHigh: prdata = key_high_q;
      RegKeyLow:  prdata = key_low_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else begin
      key_high_q <= key_high_d;
      key_low_q  <= key_low_d;
    end
  end

  // key schedule sees the key as it stands after this write
  sm4_key_sched u_key_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cfg_wr),
    .key_i  ({key_high_d, key_low_d}),
    .busy_o (ks_busy),
    .rk_o   (rk)
  );

  // pipeline moves unless a finished result is being held
  assign pipe_en    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !pipe_en || ks_busy;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign stg_valid[0]    = in_valid_i && !ks_busy;
  assign stg_data[0].x   = {in_data_i.block_high, in_data_i.block_low};
  assign stg_data[0].dec = in_data_i.opcode;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    sm4_round u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (pipe_en),
      .valid_i  (stg_valid[r]),
      .data_i   (stg_data[r]),
      .rk_enc_i (rk[r]),
      .rk_dec_i (rk[NumRounds-1-r]),
      .valid_o  (stg_valid[r+1]),
      .data_o   (stg_data[r+1])
    );
  end

  // final state holds x32..x35; result is those words reversed
  assign out_valid_o            = stg_valid[NumRounds];
  assign out_data_o.result_high = {stg_data[NumRounds].x[31:0],
                                   stg_data[NumRounds].x[63:32]};
  assign out_data_o.result_low  = {stg_data[NumRounds].x[95:64],
                                   stg_data[NumRounds].x[127:96]};

  // no block enters while the round keys are being rebuilt
  a_no_xfer_in_keygen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_busy |-> !in_xfer)
    else $error("input transfer during key schedule");

  // an accepted block shows up in the first round stage
  a_xfer_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> stg_valid[1])
    else $error("accepted block lost at pipeline entry");

  // a held result keeps the pipeline frozen, checked on the first stage's valid bit
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(stg_valid[1]))
    else $error("pipeline moved under output stall");

endmodule

>>> bench/tb_sm4_block_cipher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sm4_block_cipher_unit
// self-checking bench for the sm4 cipher unit: keys over apb, blocks streamed
// ----------------------------------------------------------------------------
// a local cipher model expands the key and computes every expected block;
// the driver feeds queued transfers, the monitor compares each result with
// the oldest expected one. keys change only with the pipeline drained.
// ----------------------------------------------------------------------------
module tb_sm4_block_cipher_unit;
  import sm4_pkg::*;

  localparam int unsigned PipeLat  = 40;
  localparam int unsigned MaxCycle = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  sm4_block_cipher_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  // cipher model state
  logic [63:0] key_hi_q = '0, key_lo_q = '0;
  logic [31:0] sched_rk [32];

  in_item_t  block_fifo[$];
  out_item_t cipher_expected[$];
  int unsigned errors = 0, n_checked = 0, n_sent = 0, n_enc = 0, n_dec = 0;
  int unsigned cycle_cnt = 0, n_keys = 0;
  int          hold_left = 0;
  bit          src_idle_ok = 1'b1, snk_idle_ok = 1'b1;
  bit          in_taken = 1'b0;

  logic [7:0] sb_tbl [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] subst_word(logic [31:0] a);
    return {sb_tbl[a[31:24]], sb_tbl[a[23:16]], sb_tbl[a[15:8]], sb_tbl[a[7:0]]};
  endfunction

  // key schedule from the two key halves
  function automatic void expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] t, ck, s;
    k[0] = key_hi_q[63:32] ^ 32'hA3B1BAC6;
    k[1] = key_hi_q[31:0]  ^ 32'h56AA3350;
    k[2] = key_lo_q[63:32] ^ 32'h677D9197;
    k[3] = key_lo_q[31:0]  ^ 32'hB27022DC;
    for (int i = 0; i < 32; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
      t = k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck;
      s = subst_word(t);
      k[i % 4] ^= s ^ rotl(s, 13) ^ rotl(s, 23);
      sched_rk[i] = k[i % 4];
    end
  endfunction

  function automatic out_item_t cipher_block(in_item_t it);
    logic [31:0] x [4];
    logic [31:0] t, s, rk;
    out_item_t r;
    x[0] = it.block_high[63:32]; x[1] = it.block_high[31:0];
    x[2] = it.block_low[63:32];  x[3] = it.block_low[31:0];
    for (int i = 0; i < 32; i++) begin
      rk = (it.opcode == OpDecrypt) ? sched_rk[31 - i] : sched_rk[i];
      t = x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4] ^ rk;
      s = subst_word(t);
      x[i % 4] ^= s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
    end
    r.result_high = {x[3], x[2]};
    r.result_low  = {x[1], x[0]};
    return r;
  endfunction

  function automatic in_item_t rand_block(bit sparse);
    in_item_t it;
    it.block_high = {$urandom, $urandom};
    it.block_low  = {$urandom, $urandom};
    if (sparse) begin
      // mostly-zero or mostly-one blocks
      if ($urandom_range(0, 1)) begin
        it.block_high &= {$urandom, $urandom}; it.block_low &= {$urandom, $urandom};
      end else begin
        it.block_high |= {$urandom, $urandom}; it.block_low |= {$urandom, $urandom};
      end
    end
    it.opcode = $urandom_range(0, 1);
    return it;
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MaxCycle) begin
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  // driver: one transfer offered at a time, payload held until an edge takes it
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else if (block_fifo.size() != 0 && !(src_idle_ok && $urandom_range(0, 99) < 19))
      begin
        in_valid_i <= 1'b1;
        in_data_i  <= block_fifo.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // predict at the accepting edge
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      cipher_expected.push_back(cipher_block(in_data_i));
      n_sent++;
      if (in_data_i.opcode == OpDecrypt) n_dec++; else n_enc++;
    end
  end

  // receiver stall: random, or a long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= snk_idle_ok && ($urandom_range(0, 99) < 19);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_expected.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        exp_r = cipher_expected.pop_front();
        n_checked++;
        if (out_data_o.result_high !== exp_r.result_high) begin
          $display("%0t result_high expected %h actual %h", $time,
                   exp_r.result_high, out_data_o.result_high);
          errors++;
        end
        if (out_data_o.result_low !== exp_r.result_low) begin
          $display("%0t result_low expected %h actual %h", $time,
                   exp_r.result_low, out_data_o.result_low);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (block_fifo.size() != 0 || in_valid_i || cipher_expected.size() != 0)
      @(posedge clk_i);
    repeat (PipeLat) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 3; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // partial update re-expands with the other half as it stands
    if (idx == RegKeyHigh) key_hi_q = val; else key_lo_q = val;
    expand_round_keys();
    n_keys++;
  endtask

  task automatic queue_stream(int n, bit sparse);
    for (int i = 0; i < n; i++) block_fifo.push_back(rand_block(sparse));
  endtask

  initial begin
    in_item_t it;
    expand_round_keys();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset key, extreme blocks, both ops
    for (int op = 0; op < 2; op++) begin
      it.opcode = opcode_e'(op);
      it.block_high = '0;  it.block_low = '0;  block_fifo.push_back(it);
      it.block_high = '1;  it.block_low = '1;  block_fifo.push_back(it);
      it.block_high = 64'h0123456789ABCDEF; it.block_low = 64'hFEDCBA9876543210;
      block_fifo.push_back(it);
    end
    wait_drained();

    // standard test key, then partial updates and extreme keys
    apb_write(RegKeyHigh, 64'h0123456789ABCDEF);
    apb_write(RegKeyLow,  64'hFEDCBA9876543210);
    it.opcode = OpEncrypt;
    it.block_high = 64'h0123456789ABCDEF; it.block_low = 64'hFEDCBA9876543210;
    block_fifo.push_back(it);
    it.opcode = OpDecrypt;
    it.block_high = 64'h681EDF34D206965E; it.block_low = 64'h86B3E94F536E4246;
    block_fifo.push_back(it);
    queue_stream(4, 1'b1);
    wait_drained();
    apb_write(RegKeyLow, '1);
    queue_stream(4, 1'b0);
    wait_drained();
    apb_write(RegKeyHigh, '1);
    queue_stream(4, 1'b1);
    wait_drained();

    // random keys, random streams; one phase without idling
    for (int ph = 0; ph < 10; ph++) begin
      apb_write(RegKeyHigh, {$urandom, $urandom});
      apb_write(RegKeyLow,  {$urandom, $urandom});
      src_idle_ok = (ph != 3);
      snk_idle_ok = (ph != 3);
      queue_stream(60, ph % 2);
      if (ph == 5) begin
        // receiver holds off long enough to back up the whole pipe
        while (block_fifo.size() > 50) @(posedge clk_i);
        @(negedge clk_i);
        hold_left = 120;
      end
      wait_drained();
    end
    src_idle_ok = 1'b1; snk_idle_ok = 1'b1;

    $display("checked %0d of %0d blocks (%0d encrypt, %0d decrypt), %0d key writes",
             n_checked, n_sent, n_enc, n_dec, n_keys);
    if (errors == 0 && cipher_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
